// ----- rtl/core/oit_pkg.sv -----
// Shared types and constants for the ordered id table.
`default_nettype none
package oit_pkg;

	localparam int ID_W    = 32;
	localparam int KEY_W   = 32;
	localparam int EDATA_W = 32;
	localparam int FDATA_W = 32;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;

	// slave-side beat: op, key_id, entry_data, zero padded to whole bytes
	localparam int IN_BITS = OP_W + KEY_W + EDATA_W;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_APPEND        = 3'd0;
	localparam op_t OP_APPEND_UNIQUE = 3'd1;
	localparam op_t OP_DELETE        = 3'd2;
	localparam op_t OP_SEARCH        = 3'd3;
	localparam op_t OP_COUNT         = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_PRESENT   = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/core/oit_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module oit_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ordered_id_table.sv -----
// Ordered id table: one beat at a time, s_tready high only while the sequencer is idle.
// Each beat scans every held entry; a delete that hits then moves the entries above the match down
// to close the gap. A result waiting in the output register holds the next one in the sequencer.
// Reset empties the table by clearing the fill count; the RAM itself is not cleared.
`default_nettype none
module ordered_id_table #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// slave side
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// op[2:0], key_id[34:3], entry_data[66:35], zero pad above
	input  wire logic [oit_pkg::IN_W-1:0] s_tdata,
	// master side
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// status[1:0], found[2], found_data[34:3], match_count, item_count,
	// is_empty, is_sorted (counts $clog2(DEPTH+1) bits each), zero pad above
	output logic [((37 + 2 * $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	import oit_pkg::*;

	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int MW       = ID_W + DATA_WIDTH;
	localparam int OUT_BITS = ST_W + 1 + FDATA_W + CW + CW + 1 + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         fill_q;
	logic                  rvalid_q;

	// per-item working registers
	op_t                   op_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] din_q;
	logic [CW-1:0]         issue_q;    // next RAM address to read
	logic [AW-1:0]         proc_q;     // index of the entry on the RAM output
	logic [AW-1:0]         wptr_q;     // write address while closing the gap
	logic                  hit_q;
	logic [AW-1:0]         first_q;
	logic [CW-1:0]         match_q;
	logic [DATA_WIDTH-1:0] fdata_q;
	logic                  sorted_q;   // order of the table as it stands
	logic [ID_W-1:0]       prev_q;     // last id seen, ends as the tail id
	logic                  dsorted_q;  // order with the first match taken out
	logic [ID_W-1:0]       dprev_q;
	logic                  dprev_v_q;
	status_t               status_q;

	// RAM interface, entry layout {data, id}
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [MW-1:0]         ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [MW-1:0]         ram_rdata;

	logic [ID_W-1:0]       rd_id;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  accept;
	logic                  scan_issue;
	logic                  shift_issue;
	logic                  scan_end;
	logic                  shift_end;
	logic                  full;
	logic                  store;
	logic                  del_hit;
	logic                  eq;
	logic                  first_hit;
	logic                  out_load;
	logic [64:0]           din_ext;
	logic [64:0]           fdata_ext;
	logic                  tail_ok;

	oit_ram #(
		.WIDTH (MW),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign rd_id   = ram_rdata[ID_W-1:0];
	assign rd_data = ram_rdata[MW-1:ID_W];

	// keep only the low DATA_WIDTH bits of the payload, zero-extend when wider
	assign din_ext   = {33'b0, s_tdata[OP_W+KEY_W+:EDATA_W]};
	assign fdata_ext = {{(65 - DATA_WIDTH){1'b0}}, fdata_q};

	// walk every held entry once; after a hit on delete, read entries above the gap
	assign scan_issue  = (state_q == S_SCAN) && (issue_q < fill_q);
	assign shift_issue = (state_q == S_SHIFT) && (issue_q <= fill_q);
	assign scan_end    = (state_q == S_SCAN) && (issue_q == fill_q) && !rvalid_q;
	assign shift_end   = (state_q == S_SHIFT) && (issue_q > fill_q) && !rvalid_q;

	assign full    = (fill_q == CW'(DEPTH));
	assign store   = scan_end && !full &&
	                 ((op_q == OP_APPEND) || ((op_q == OP_APPEND_UNIQUE) && !hit_q));
	assign del_hit = scan_end && (op_q == OP_DELETE) && hit_q;

	// the shared compare unit: one entry against the key
	assign eq        = (rd_id == key_q);
	assign first_hit = rvalid_q && eq && !hit_q;

	// a new tail keeps the order when it is not below the old tail
	assign tail_ok = (fill_q == '0) || (prev_q <= key_q);

	assign ram_re    = scan_issue || shift_issue;
	assign ram_raddr = issue_q[AW-1:0];
	assign ram_we    = store || ((state_q == S_SHIFT) && rvalid_q);
	assign ram_waddr = store ? fill_q[AW-1:0] : wptr_q;
	assign ram_wdata = store ? {din_q, key_q} : ram_rdata;

	assign out_load = (state_q == S_DONE) && (!m_tvalid || m_tready);

	// sequencer and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			rvalid_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// load a new result, else drop the beat once it is taken
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					rvalid_q <= 1'b0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rvalid_q <= scan_issue;
					if (scan_end) begin
						if (del_hit) begin
							fill_q  <= fill_q - 1'b1;
							state_q <= S_SHIFT;
						end else begin
							if (store) begin
								fill_q <= fill_q + 1'b1;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					rvalid_q <= shift_issue;
					if (shift_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rvalid_q <= 1'b0;
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: walk results, outcome and the output beat
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= s_tdata[OP_W-1:0];
					key_q     <= s_tdata[OP_W+:KEY_W];
					din_q     <= din_ext[DATA_WIDTH-1:0];
					issue_q   <= '0;
					proc_q    <= '0;
					hit_q     <= 1'b0;
					match_q   <= '0;
					fdata_q   <= '0;
					sorted_q  <= 1'b1;
					dsorted_q <= 1'b1;
					dprev_v_q <= 1'b0;
					status_q  <= ST_OK;
				end
			end
			S_SCAN: begin
				if (scan_issue) begin
					issue_q <= issue_q + 1'b1;
				end
				if (rvalid_q) begin
					proc_q <= proc_q + 1'b1;
					if (eq) begin
						match_q <= match_q + 1'b1;
					end
					if (first_hit) begin
						hit_q   <= 1'b1;
						first_q <= proc_q;
						fdata_q <= rd_data;
					end
					if ((proc_q != '0) && (prev_q > rd_id)) begin
						sorted_q <= 1'b0;
					end
					prev_q <= rd_id;
					// order of the table as it would stand after deleting the first match
					if (!first_hit) begin
						if (dprev_v_q && (dprev_q > rd_id)) begin
							dsorted_q <= 1'b0;
						end
						dprev_q   <= rd_id;
						dprev_v_q <= 1'b1;
					end
				end
				if (scan_end) begin
					// payload reports only on a search that hits
					if ((op_q != OP_SEARCH) || !hit_q) begin
						fdata_q <= '0;
					end
					unique case (op_q)
						OP_APPEND: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								sorted_q <= sorted_q && tail_ok;
							end
						end
						OP_APPEND_UNIQUE: begin
							if (hit_q) begin
								status_q <= ST_PRESENT;
							end else if (full) begin
								status_q <= ST_FULL;
							end else begin
								sorted_q <= sorted_q && tail_ok;
							end
						end
						OP_DELETE: begin
							if (!hit_q) begin
								status_q <= ST_NOT_FOUND;
							end else begin
								sorted_q <= dsorted_q;
								issue_q  <= CW'(first_q) + 1'b1;
								wptr_q   <= first_q;
							end
						end
						OP_SEARCH: begin
							if (!hit_q) begin
								status_q <= ST_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT: begin
				// advance one entry down per cycle to close the gap
				if (shift_issue) begin
					issue_q <= issue_q + 1'b1;
				end
				if (rvalid_q) begin
					wptr_q <= wptr_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_load) begin
					m_tdata <= {{(OUT_W - OUT_BITS){1'b0}},
					            sorted_q,
					            (fill_q == '0),
					            fill_q,
					            match_q,
					            fdata_ext[FDATA_W-1:0],
					            hit_q,
					            status_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
